@@ design/coap_option_stream_decoder_defines.svh @@
// Assertion macros for the option stream decoder output stage.
`ifndef COAP_OPTION_STREAM_DECODER_DEFINES_SVH
`define COAP_OPTION_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define COAP_OSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define COAP_OSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/coap_osd_pkg.sv @@
// Shared types and constants of the CoAP option stream decoder.
`default_nettype none

package coap_osd_pkg;

    // Longest message in bytes; byte position saturates here.
    localparam int unsigned MAX_MESSAGE_BYTES = 65535;

    // Depth of the step queue between parser and output stage.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Result kinds
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_TRUNCATED = 2'd0;
    localparam logic [1:0] ERR_OVERRUN   = 2'd1;
    localparam logic [1:0] ERR_TOO_MANY  = 2'd2;

    // Configuration register index
    localparam logic REG_MAX_OPTIONS = 1'b0;

    // One result
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] opt_number;
        logic [15:0] value_len;
        logic [15:0] payload_offset;
        logic [15:0] consumed_bytes;
        logic [7:0]  option_count;
        logic [1:0]  error_code;
    } res_t;

    // Results of one byte: a first result, optionally followed by done
    typedef struct packed {
        res_t        first;
        logic        then_done;
        logic [15:0] done_bytes;
    } step_t;

endpackage

`default_nettype wire

@@ design/coap_osd_front.sv @@
// Parser front end: decodes option headers one byte per cycle, while take is high, into result steps.
`default_nettype none

module coap_osd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [7:0]           msg_byte,
    input  wire logic                 first_byte,
    input  wire logic                 last_byte,
    input  wire logic [7:0]           max_options,
    output logic                      step_valid,
    output coap_osd_pkg::step_t       step
);

    // Parser phase codes
    localparam logic [2:0] PH_HEADER       = 3'd0;
    localparam logic [2:0] PH_EXT_DELTA_HI = 3'd1;
    localparam logic [2:0] PH_EXT_DELTA_LO = 3'd2;
    localparam logic [2:0] PH_EXT_LEN_HI   = 3'd3;
    localparam logic [2:0] PH_EXT_LEN_LO   = 3'd4;
    localparam logic [2:0] PH_VALUE        = 3'd5;
    localparam logic [2:0] PH_STOPPED      = 3'd6;

    localparam logic [15:0] POS_LIMIT = 16'(coap_osd_pkg::MAX_MESSAGE_BYTES);
    localparam logic [15:0] EXT1_BASE = 16'd13;
    localparam logic [15:0] EXT2_BASE = 16'd269;
    localparam logic [3:0]  NIB_EXT1  = 4'd13;
    localparam logic [3:0]  NIB_EXT2  = 4'd14;

    logic [2:0]  phase_reg,  phase_next;
    logic [15:0] prev_reg,   prev_next;
    logic [15:0] delta_reg,  delta_next;
    logic [15:0] len_reg,    len_next;
    logic [3:0]  nib_reg,    nib_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] pos_reg,    pos_next;
    logic [7:0]  seen_reg,   seen_next;

    // state as seen by this byte (cleared on first byte)
    logic [2:0]  ph;
    logic [15:0] pn, da, la, pr, bp;
    logic [3:0]  ln;
    logic [7:0]  os;

    logic [3:0]  d_nib, l_nib;
    logic        start_req;
    logic [3:0]  start_nib;
    logic        hdr_req;
    logic [15:0] hdr_len;
    logic        rec_req;
    logic [15:0] rec_len, rec_off;
    logic        fail_req;
    logic [1:0]  fail_code;
    logic [15:0] remain_dec;
    logic        emit;

    // Byte decode
    always_comb
    begin
        if (first_byte)
        begin
            ph = PH_HEADER;
            pn = '0;
            da = '0;
            la = '0;
            ln = '0;
            pr = '0;
            bp = '0;
            os = '0;
        end
        else
        begin
            ph = phase_reg;
            pn = prev_reg;
            da = delta_reg;
            la = len_reg;
            ln = nib_reg;
            pr = remain_reg;
            bp = pos_reg;
            os = seen_reg;
        end

        d_nib       = msg_byte[7:4];
        l_nib       = msg_byte[3:0];
        remain_dec  = pr - 16'd1;

        phase_next  = ph;
        prev_next   = pn;
        delta_next  = da;
        len_next    = la;
        nib_next    = ln;
        remain_next = pr;
        seen_next   = os;
        pos_next    = (bp < POS_LIMIT) ? bp + 16'd1 : bp;

        start_req = 1'b0;
        start_nib = '0;
        hdr_req   = 1'b0;
        hdr_len   = '0;
        rec_req   = 1'b0;
        rec_len   = '0;
        rec_off   = '0;
        fail_req  = 1'b0;
        fail_code = coap_osd_pkg::ERR_TRUNCATED;
        emit      = 1'b0;
        step      = '0;

        // phase step
        if (ph >= PH_STOPPED)
        begin
            emit = 1'b0;
        end
        else if (bp >= POS_LIMIT)
        begin
            fail_req  = 1'b1;
            fail_code = coap_osd_pkg::ERR_OVERRUN;
        end
        else
        begin
            case (ph)
                PH_HEADER:
                begin
                    if (msg_byte == 8'hFF)
                    begin
                        phase_next                = PH_STOPPED;
                        emit                      = 1'b1;
                        step.first.kind           = coap_osd_pkg::KIND_DONE;
                        step.first.consumed_bytes = bp;
                        step.first.option_count   = os;
                    end
                    else if (os >= max_options)
                    begin
                        fail_req  = 1'b1;
                        fail_code = coap_osd_pkg::ERR_TOO_MANY;
                    end
                    else if (d_nib == NIB_EXT1 || d_nib == NIB_EXT2)
                    begin
                        if (last_byte)
                        begin
                            fail_req  = 1'b1;
                            fail_code = coap_osd_pkg::ERR_TRUNCATED;
                        end
                        else
                        begin
                            delta_next = (d_nib == NIB_EXT1) ? EXT1_BASE : EXT2_BASE;
                            nib_next   = l_nib;
                            phase_next = (d_nib == NIB_EXT1) ? PH_EXT_DELTA_LO
                                                             : PH_EXT_DELTA_HI;
                        end
                    end
                    else
                    begin
                        delta_next = {12'd0, d_nib};
                        start_req  = 1'b1;
                        start_nib  = l_nib;
                    end
                end
                PH_EXT_DELTA_HI,
                PH_EXT_LEN_HI:
                begin
                    if (last_byte)
                    begin
                        fail_req  = 1'b1;
                        fail_code = coap_osd_pkg::ERR_TRUNCATED;
                    end
                    else if (ph == PH_EXT_DELTA_HI)
                    begin
                        delta_next = da + {msg_byte, 8'h00};
                        phase_next = PH_EXT_DELTA_LO;
                    end
                    else
                    begin
                        len_next   = la + {msg_byte, 8'h00};
                        phase_next = PH_EXT_LEN_LO;
                    end
                end
                PH_EXT_DELTA_LO:
                begin
                    delta_next = da + {8'd0, msg_byte};
                    start_req  = 1'b1;
                    start_nib  = ln;
                end
                PH_EXT_LEN_LO:
                begin
                    hdr_req = 1'b1;
                    hdr_len = la + {8'd0, msg_byte};
                end
                PH_VALUE:
                begin
                    remain_next = remain_dec;
                    if (remain_dec == 16'd0)
                    begin
                        rec_req = 1'b1;
                        rec_len = la;
                        rec_off = bp + 16'd1 - la;
                    end
                    else if (last_byte)
                    begin
                        fail_req  = 1'b1;
                        fail_code = coap_osd_pkg::ERR_OVERRUN;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        // length nibble: extended or plain
        if (start_req)
        begin
            if (start_nib == NIB_EXT1 || start_nib == NIB_EXT2)
            begin
                if (last_byte)
                begin
                    fail_req  = 1'b1;
                    fail_code = coap_osd_pkg::ERR_TRUNCATED;
                end
                else
                begin
                    len_next   = (start_nib == NIB_EXT1) ? EXT1_BASE : EXT2_BASE;
                    phase_next = (start_nib == NIB_EXT1) ? PH_EXT_LEN_LO : PH_EXT_LEN_HI;
                end
            end
            else
            begin
                hdr_req = 1'b1;
                hdr_len = {12'd0, start_nib};
            end
        end

        // header complete: new option number, then value, empty record, or overrun on the last byte
        if (hdr_req)
        begin
            prev_next = pn + delta_next;
            if (hdr_len == 16'd0)
            begin
                rec_req = 1'b1;
                rec_len = '0;
                rec_off = bp + 16'd1;
            end
            else if (last_byte)
            begin
                fail_req  = 1'b1;
                fail_code = coap_osd_pkg::ERR_OVERRUN;
            end
            else
            begin
                len_next    = hdr_len;
                remain_next = hdr_len;
                phase_next  = PH_VALUE;
            end
        end

        // option record, followed by done on the final byte
        if (rec_req)
        begin
            seen_next                 = os + 8'd1;
            emit                      = 1'b1;
            step.first.kind           = coap_osd_pkg::KIND_RECORD;
            step.first.opt_number     = prev_next;
            step.first.value_len      = rec_len;
            step.first.payload_offset = rec_off;
            step.first.option_count   = seen_next;
            step.then_done            = last_byte;
            step.done_bytes           = bp + 16'd1;
            phase_next                = last_byte ? PH_STOPPED : PH_HEADER;
        end

        if (fail_req)
        begin
            phase_next              = PH_STOPPED;
            emit                    = 1'b1;
            step.first.kind         = coap_osd_pkg::KIND_ERROR;
            step.first.option_count = seen_next;
            step.first.error_code   = fail_code;
        end
    end

    assign step_valid = take && emit;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            prev_reg   <= '0;
            delta_reg  <= '0;
            len_reg    <= '0;
            nib_reg    <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            seen_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            delta_reg  <= delta_next;
            len_reg    <= len_next;
            nib_reg    <= nib_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

`default_nettype wire

@@ design/coap_osd_queue.sv @@
// Short step queue between the parser and the output stage.
`default_nettype none

module coap_osd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire coap_osd_pkg::step_t  wr_data,
    input  wire logic                 rd_en,
    output coap_osd_pkg::step_t       rd_data,
    output logic                      full,
    output logic                      nonempty
);

    localparam int unsigned AW = coap_osd_pkg::QUEUE_AW;

    coap_osd_pkg::step_t entries_reg [coap_osd_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg,  count_next;

    assign full     = (count_reg == (AW+1)'(coap_osd_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = entries_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(coap_osd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(coap_osd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ design/coap_osd_back.sv @@
// Output stage: unpacks queued steps into single results behind an output register.
`default_nettype none

`include "coap_option_stream_decoder_defines.svh"

module coap_osd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_nonempty,
    input  wire coap_osd_pkg::step_t  q_data,
    output logic                      q_rd,
    input  wire logic                 pop,
    output logic                      empty,
    output coap_osd_pkg::res_t        res,
    output logic                      last_result
);

    logic                out_valid_reg;
    coap_osd_pkg::res_t  out_reg;
    logic                out_last_reg;
    logic                pending_reg;
    logic [15:0]         pending_bytes_reg;
    logic                advance;

    assign advance     = !out_valid_reg || pop;
    assign q_rd        = advance && !pending_reg && q_nonempty;
    assign empty       = !out_valid_reg;
    assign res         = out_reg;
    assign last_result = out_last_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (pending_reg)
            begin
                out_valid_reg <= 1'b1;
                pending_reg   <= 1'b0;
            end
            else
            begin
                out_valid_reg <= q_nonempty;
                pending_reg   <= q_nonempty && q_data.then_done;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pending_reg)
            begin
                // done after the record that ended the message
                out_reg.kind           <= coap_osd_pkg::KIND_DONE;
                out_reg.opt_number     <= '0;
                out_reg.value_len      <= '0;
                out_reg.payload_offset <= '0;
                out_reg.consumed_bytes <= pending_bytes_reg;
                out_reg.error_code     <= coap_osd_pkg::ERR_TRUNCATED;
                out_last_reg           <= 1'b1;
            end
            else if (q_nonempty)
            begin
                out_reg           <= q_data.first;
                out_last_reg      <= !q_data.then_done;
                pending_bytes_reg <= q_data.done_bytes;
            end
        end
    end

    // Checks
    `COAP_OSD_ASSERT_IMP(a_pending_has_output, pending_reg, out_valid_reg,
        "pending done without a result on the output")
    `COAP_OSD_ASSERT_IMP(a_not_last_means_pending, out_valid_reg && !out_last_reg,
        pending_reg && out_reg.kind == coap_osd_pkg::KIND_RECORD,
        "non-final result must be a record with done pending")
    `COAP_OSD_ASSERT_NXT(a_done_follows, out_valid_reg && pending_reg && pop,
        out_valid_reg && out_last_reg && out_reg.kind == coap_osd_pkg::KIND_DONE,
        "done must follow the record of the final byte")

endmodule

`default_nettype wire

@@ design/coap_option_stream_decoder.sv @@
// Top level of the CoAP option stream decoder: config register, parser, queue, output.
//
//   channel   direction  handshake               payload
//   input     in         push / full             msg_byte, first_byte, last_byte
//   result    out        empty / pop             kind .. error_code, last_result
//   config    in         psel, penable, pwrite   paddr, pwdata, prdata (max_options)
//
// One byte is accepted per cycle unless full is high; each byte is settled in the cycle it is taken.
// A byte yielding a record and done gives two results, so the result side limits
// throughput; the four-entry step queue absorbs that, and full rises only when it fills.
// A result passes through the step queue and then the output register to the ports.
// Reset clears the parser to header start and sets max_options to 16; no clearing pass.
`default_nettype none

module coap_option_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input bytes
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    // results
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       kind,
    output logic [15:0]      opt_number,
    output logic [15:0]      value_len,
    output logic [15:0]      payload_offset,
    output logic [15:0]      consumed_bytes,
    output logic [7:0]       option_count,
    output logic [1:0]       error_code,
    output logic             last_result,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                 take;
    logic                 step_valid;
    coap_osd_pkg::step_t  step;
    coap_osd_pkg::step_t  q_data;
    logic                 q_rd;
    logic                 q_nonempty;
    coap_osd_pkg::res_t   res;
    logic [7:0]           max_options_reg;
    logic                 reg_index;
    logic                 cfg_write;

    // Configuration register
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == coap_osd_pkg::REG_MAX_OPTIONS)
                       ? {24'd0, max_options_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_options_reg <= 8'd16;
        end
        else if (cfg_write && reg_index == coap_osd_pkg::REG_MAX_OPTIONS)
        begin
            max_options_reg <= pwdata[7:0];
        end
    end

    // Input request taken
    assign take = push && !full;

    coap_osd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .msg_byte    (msg_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .max_options (max_options_reg),
        .step_valid  (step_valid),
        .step        (step)
    );

    coap_osd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (step_valid),
        .wr_data  (step),
        .rd_en    (q_rd),
        .rd_data  (q_data),
        .full     (full),
        .nonempty (q_nonempty)
    );

    coap_osd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .q_data      (q_data),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .res         (res),
        .last_result (last_result)
    );

    // Result ports
    assign kind           = res.kind;
    assign opt_number     = res.opt_number;
    assign value_len      = res.value_len;
    assign payload_offset = res.payload_offset;
    assign consumed_bytes = res.consumed_bytes;
    assign option_count   = res.option_count;
    assign error_code     = res.error_code;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the CoAP option stream decoder: directed and random byte streams checked
// against an in-bench decoder model.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned SETTLE_GAP   = 8;
    localparam logic [1:0]  ERR_NONE     = 2'd0;

    // Parser position inside the option area
    typedef enum logic [2:0] {
        AT_HEADER,
        AT_DELTA_HI,
        AT_DELTA_LO,
        AT_LEN_HI,
        AT_LEN_LO,
        AT_VALUE,
        AT_STOPPED
    } parse_phase_e;

    // One decoder result as seen on the result ports
    typedef struct packed {
        coap_osd_pkg::res_t body;
        logic               closing;
    } decoded_t;

    // One byte request waiting to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       opens;
        logic       closes;
    } byte_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  msg_byte = '0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        pop = 1'b0;
    logic        empty;
    logic [1:0]  kind;
    logic [15:0] opt_number;
    logic [15:0] value_len;
    logic [15:0] payload_offset;
    logic [15:0] consumed_bytes;
    logic [7:0]  option_count;
    logic [1:0]  error_code;
    logic        last_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    coap_option_stream_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .msg_byte       (msg_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .opt_number     (opt_number),
        .value_len      (value_len),
        .payload_offset (payload_offset),
        .consumed_bytes (consumed_bytes),
        .option_count   (option_count),
        .error_code     (error_code),
        .last_result    (last_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder model state
    parse_phase_e parse_phase   = AT_HEADER;
    logic [15:0]  option_base   = '0;
    logic [15:0]  delta_sum     = '0;
    logic [15:0]  length_sum    = '0;
    logic [3:0]   held_len_nib  = '0;
    logic [15:0]  value_left    = '0;
    logic [15:0]  byte_index    = '0;
    logic [7:0]   option_total  = '0;
    logic [7:0]   option_limit  = 8'd16;

    decoded_t    step_results[$];
    decoded_t    pending_results[$];
    byte_entry_t byte_feed[$];
    byte_entry_t outgoing;
    logic [7:0]  msg_bytes[$];

    int unsigned send_idle_pct  = 20;
    int unsigned take_stall_pct = 20;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned random_count   = 0;

    function automatic void emit(logic [1:0] k, logic [15:0] num, logic [15:0] len,
                                 logic [15:0] off, logic [15:0] br, logic [1:0] err);
        decoded_t r;
        r.body.kind           = k;
        r.body.opt_number     = num;
        r.body.value_len      = len;
        r.body.payload_offset = off;
        r.body.consumed_bytes = br;
        r.body.option_count   = option_total;
        r.body.error_code     = err;
        r.closing             = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void stop_with(logic [1:0] err);
        parse_phase = AT_STOPPED;
        emit(coap_osd_pkg::KIND_ERROR, '0, '0, '0, '0, err);
    endfunction

    // Option complete: record, then done when the message ends here
    function automatic void close_option(logic [15:0] len, logic [15:0] off, logic at_end);
        option_total = option_total + 8'd1;
        emit(coap_osd_pkg::KIND_RECORD, option_base, len, off, '0, ERR_NONE);
        if (at_end)
        begin
            parse_phase = AT_STOPPED;
            emit(coap_osd_pkg::KIND_DONE, '0, '0, '0, byte_index + 16'd1, ERR_NONE);
        end
        else
            parse_phase = AT_HEADER;
    endfunction

    function automatic void end_header(logic [15:0] len, logic at_end);
        option_base = option_base + delta_sum;
        if (len == 16'd0)
            close_option('0, byte_index + 16'd1, at_end);
        else if (at_end)
            stop_with(coap_osd_pkg::ERR_OVERRUN);
        else
        begin
            length_sum  = len;
            value_left  = len;
            parse_phase = AT_VALUE;
        end
    endfunction

    // Length nibble: 13 and 14 pull in extension bytes
    function automatic void begin_length(logic [3:0] nib, logic at_end);
        if (nib == 4'd13 || nib == 4'd14)
        begin
            if (at_end)
                stop_with(coap_osd_pkg::ERR_TRUNCATED);
            else
            begin
                length_sum  = (nib == 4'd13) ? 16'd13 : 16'd269;
                parse_phase = (nib == 4'd13) ? AT_LEN_LO : AT_LEN_HI;
            end
        end
        else
            end_header({12'd0, nib}, at_end);
    endfunction

    // Expected results of one accepted byte
    function automatic void decode_byte(logic [7:0] b, logic opens, logic closes);
        logic [3:0] dn;
        logic [3:0] ln;
        dn = b[7:4];
        ln = b[3:0];
        step_results.delete();
        if (opens)
        begin
            parse_phase  = AT_HEADER;
            option_base  = '0;
            delta_sum    = '0;
            length_sum   = '0;
            held_len_nib = '0;
            value_left   = '0;
            byte_index   = '0;
            option_total = '0;
        end
        if (parse_phase == AT_STOPPED)
        begin
            // quiet until the next message
        end
        else if (byte_index >= coap_osd_pkg::MAX_MESSAGE_BYTES)
            stop_with(coap_osd_pkg::ERR_OVERRUN);
        else
        begin
            case (parse_phase)
                AT_HEADER:
                begin
                    if (b == 8'hFF)
                    begin
                        parse_phase = AT_STOPPED;
                        emit(coap_osd_pkg::KIND_DONE, '0, '0, '0, byte_index, ERR_NONE);
                    end
                    else if (option_total >= option_limit)
                        stop_with(coap_osd_pkg::ERR_TOO_MANY);
                    else if (dn == 4'd13 || dn == 4'd14)
                    begin
                        if (closes)
                            stop_with(coap_osd_pkg::ERR_TRUNCATED);
                        else
                        begin
                            delta_sum    = (dn == 4'd13) ? 16'd13 : 16'd269;
                            held_len_nib = ln;
                            parse_phase  = (dn == 4'd13) ? AT_DELTA_LO : AT_DELTA_HI;
                        end
                    end
                    else
                    begin
                        delta_sum = {12'd0, dn};
                        begin_length(ln, closes);
                    end
                end
                AT_DELTA_HI, AT_LEN_HI:
                begin
                    if (closes)
                        stop_with(coap_osd_pkg::ERR_TRUNCATED);
                    else if (parse_phase == AT_DELTA_HI)
                    begin
                        delta_sum   = delta_sum + {b, 8'h00};
                        parse_phase = AT_DELTA_LO;
                    end
                    else
                    begin
                        length_sum  = length_sum + {b, 8'h00};
                        parse_phase = AT_LEN_LO;
                    end
                end
                AT_DELTA_LO:
                begin
                    delta_sum = delta_sum + {8'h00, b};
                    begin_length(held_len_nib, closes);
                end
                AT_LEN_LO:
                    end_header(length_sum + {8'h00, b}, closes);
                default:
                begin
                    value_left = value_left - 16'd1;
                    if (value_left == 16'd0)
                        close_option(length_sum, byte_index + 16'd1 - length_sum, closes);
                    else if (closes)
                        stop_with(coap_osd_pkg::ERR_OVERRUN);
                end
            endcase
        end
        if (byte_index < coap_osd_pkg::MAX_MESSAGE_BYTES)
            byte_index = byte_index + 16'd1;
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].closing = 1'b1;
        foreach (step_results[i])
            pending_results.push_back(step_results[i]);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Queue msg_bytes as one message
    function automatic void send_msg(logic opens, logic closes);
        byte_entry_t e;
        foreach (msg_bytes[i])
        begin
            e.data   = msg_bytes[i];
            e.opens  = opens && (i == 0);
            e.closes = closes && (i == msg_bytes.size() - 1);
            byte_feed.push_back(e);
        end
    endfunction

    // Append one well-formed option with random delta, length and value
    function automatic void add_option();
        logic [3:0]  dn;
        logic [3:0]  ln;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  delta_ext[$];
        logic [7:0]  len_ext[$];
        int unsigned dsel;
        int unsigned lsel;
        int unsigned vlen;
        dsel = $urandom_range(99);
        if (dsel < 60)
        begin
            dn = 4'($urandom_range(12));
            if ($urandom_range(9) == 0)
                dn = 4'd15;
        end
        else if (dsel < 80)
        begin
            dn = 4'd13;
            delta_ext.push_back(8'($urandom_range(255)));
        end
        else
        begin
            dn = 4'd14;
            delta_ext.push_back(8'($urandom_range(255)));
            delta_ext.push_back(8'($urandom_range(255)));
        end
        lsel = $urandom_range(99);
        if (lsel < 70)
        begin
            ln = 4'($urandom_range(12));
            if ($urandom_range(9) == 0)
                ln = 4'd15;
            vlen = ln;
        end
        else if (lsel < 88)
        begin
            ln = 4'd13;
            lo = 8'($urandom_range(20));
            len_ext.push_back(lo);
            vlen = 13 + lo;
        end
        else
        begin
            // two-byte length: long, or wrapping around to something short
            ln = 4'd14;
            case ($urandom_range(2))
                0:
                begin
                    hi = 8'h00;
                    lo = 8'($urandom_range(31));
                end
                1:
                begin
                    hi = 8'hFE;
                    lo = 8'($urandom_range(8'hF3, 8'hFF));
                end
                default:
                begin
                    hi = 8'hFF;
                    lo = 8'($urandom_range(40));
                end
            endcase
            len_ext.push_back(hi);
            len_ext.push_back(lo);
            vlen = (269 + {hi, lo}) % 65536;
        end
        // 0xFF would read as the payload marker
        if (dn == 4'd15 && ln == 4'd15)
            dn = 4'd12;
        msg_bytes.push_back({dn, ln});
        foreach (delta_ext[i])
            msg_bytes.push_back(delta_ext[i]);
        foreach (len_ext[i])
            msg_bytes.push_back(len_ext[i]);
        for (int unsigned i = 0; i < vlen; i++)
            msg_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // Random message: mostly well-formed, some cut short, some noise
    function automatic void queue_message();
        int unsigned flavor;
        int unsigned n_opts;
        int unsigned cut;
        int unsigned n_tail;
        logic        opens;
        msg_bytes.delete();
        flavor = $urandom_range(99);
        opens  = ($urandom_range(19) != 0);
        n_tail = 0;
        if (flavor < 85)
        begin
            if (option_limit < 20 && $urandom_range(3) == 0)
                n_opts = option_limit + 1;
            else
                n_opts = $urandom_range(6);
            for (int unsigned i = 0; i < n_opts; i++)
                add_option();
            if (n_opts == 0 || $urandom_range(9) < 4)
            begin
                msg_bytes.push_back(8'hFF);
                n_tail = $urandom_range(3);
            end
            if (flavor >= 70)
            begin
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut)
                    void'(msg_bytes.pop_back());
                n_tail = 0;
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                msg_bytes.push_back(8'($urandom_range(255)));
        end
        random_count += msg_bytes.size();
        send_msg(opens, n_tail == 0);
        // payload after the marker is ignored by the block
        if (n_tail != 0)
        begin
            msg_bytes.delete();
            repeat (n_tail)
                msg_bytes.push_back(8'($urandom_range(255)));
            send_msg(1'b0, 1'b1);
        end
    endfunction

    // Byte sender
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                decode_byte(msg_byte, first_byte, last_byte);
            if (!push || !full)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    outgoing = byte_feed.pop_front();
                    push       <= 1'b1;
                    msg_byte   <= outgoing.data;
                    first_byte <= outgoing.opens;
                    last_byte  <= outgoing.closes;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result kind %0d with none expected", $time, kind);
                end
                else
                begin
                    check_field("kind", pending_results[0].body.kind, kind);
                    check_field("opt_number", pending_results[0].body.opt_number,
                                opt_number);
                    check_field("value_len", pending_results[0].body.value_len,
                                value_len);
                    check_field("payload_offset", pending_results[0].body.payload_offset,
                                payload_offset);
                    check_field("consumed_bytes", pending_results[0].body.consumed_bytes,
                                consumed_bytes);
                    check_field("option_count", pending_results[0].body.option_count,
                                option_count);
                    check_field("error_code", pending_results[0].body.error_code, error_code);
                    check_field("last_result", pending_results[0].closing, last_result);
                    void'(pending_results.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time,
                     pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Wait until every byte is taken and every result has come back
    task automatic drain();
        while (byte_feed.size() != 0 || push || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic write_max_options(logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {coap_osd_pkg::REG_MAX_OPTIONS, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        option_limit = value;
    endtask

    // Stimulus sequence
    initial
    begin
        int unsigned round;
        int unsigned target;
        logic [7:0]  limit;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit; first message has no start flag
        msg_bytes = '{8'h00, 8'hD1, 8'hFF, 8'h80, 8'hE0, 8'hFF, 8'hFF, 8'hF2, 8'h5A,
                      8'hA5, 8'h0E, 8'hFE, 8'hF3, 8'hFF};
        send_msg(1'b0, 1'b1);
        // record on the final byte, then bytes after done
        msg_bytes = '{8'h00};
        send_msg(1'b1, 1'b1);
        msg_bytes = '{8'h22};
        send_msg(1'b0, 1'b1);
        // truncated headers
        msg_bytes = '{8'hD0};
        send_msg(1'b1, 1'b1);
        msg_bytes = '{8'h0E, 8'h01};
        send_msg(1'b1, 1'b1);
        // value cut short
        msg_bytes = '{8'h03, 8'hAA};
        send_msg(1'b1, 1'b1);
        drain();

        // Smallest limit
        write_max_options(8'd1);
        msg_bytes = '{8'h00, 8'h00, 8'h00};
        send_msg(1'b1, 1'b1);
        drain();

        // Largest limit: 255 options, then one too many
        write_max_options(8'd255);
        msg_bytes.delete();
        repeat (256)
            msg_bytes.push_back(8'h00);
        send_msg(1'b1, 1'b1);
        drain();

        // Random rounds, each at its own limit
        round = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(5))
                0: limit = 8'd1;
                1: limit = 8'd2;
                2: limit = 8'd255;
                3: limit = 8'd16;
                default: limit = 8'($urandom_range(1, 255));
            endcase
            write_max_options(limit);
            send_idle_pct  = (round == 2) ? 0 : 20;
            take_stall_pct = send_idle_pct;
            target = random_count + 150;
            while (random_count < target)
                queue_message();
            drain();
            round++;
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
